/* hw/rtl/serial_message_mailbox_router_core_defines.svh */
// Assertion macros for the serial message mailbox router.
// Included by the RTL files that carry concurrent assertions; needs no package.
`ifndef SERIAL_MESSAGE_MAILBOX_ROUTER_CORE_DEFINES_SVH
`define SERIAL_MESSAGE_MAILBOX_ROUTER_CORE_DEFINES_SVH

// The condition must imply the consequence in the same cycle.
`define SMMR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smmr assertion failed");

// The condition must imply the consequence in the next cycle.
`define SMMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smmr assertion failed");

`endif

/* hw/rtl/smmr_pkg.sv */
// Shared types and constants of the serial message mailbox router.
// Used by the channel interfaces and the core; depends on nothing.
package smmr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] bank_type;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_OWN_ID   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_ONE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PEER_TWO = 2'd2;

   localparam byte_type CH_END      = 8'h20;
   localparam byte_type CH_POLL_ONE = 8'h54;
   localparam byte_type CH_POLL_TWO = 8'h44;
   localparam byte_type CH_ON       = 8'h4F;
   localparam byte_type CH_OFF      = 8'h46;
   localparam byte_type CH_LAMP     = 8'h33;

   localparam byte_type OWN_ID_RESET   = 8'd52;
   localparam byte_type PEER_ONE_RESET = 8'd49;
   localparam byte_type PEER_TWO_RESET = 8'd50;

   localparam bank_type BANK_LINE  = 2'd0;
   localparam bank_type BANK_BOX1  = 2'd1;
   localparam bank_type BANK_BOX2  = 2'd2;
   localparam bank_type BANK_SPARE = 2'd3;

endpackage

/* hw/rtl/smmr_if.sv */
// Valid/ready channel interfaces of the serial message mailbox router.
// Depends on smmr_pkg for field types and widths.
interface smmr_req_if;
   import smmr_pkg::*;
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface smmr_rsp_if;
   import smmr_pkg::*;
   logic     valid;
   logic     ready;
   logic     out_kind;
   byte_type out_byte;
   logic     lamp_on;
   logic     last;
   modport source (output valid, output out_kind, output out_byte, output lamp_on,
                   output last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input lamp_on,
                 input last, output ready);
endinterface

interface smmr_csr_if;
   import smmr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   byte_type               data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/serial_message_mailbox_router_core.sv */
// A line's first result, if any, comes from the output register after the ending space
// transfer has loaded the sequencer. Throughput: one byte per cycle while no space waits;
// results leave at one per cycle from the buffer memory port unless rsp_ch stalls.
// A space waits while an earlier line still issues results.
// Reset is synchronous; buffer memory contents are not cleared, fill counts guard them.
`include "serial_message_mailbox_router_core_defines.svh"

module serial_message_mailbox_router_core #(
   parameter int LINE_BYTES = 15
) (
   input logic        clock,
   input logic        reset,
   smmr_req_if.sink   req_ch,
   smmr_rsp_if.source rsp_ch,
   smmr_csr_if.sink   csr_ch
);
   import smmr_pkg::*;

   localparam int CNT_W     = $clog2(LINE_BYTES + 1);
   localparam int IDX_W     = $clog2(LINE_BYTES);
   localparam int MEM_DEPTH = 4 << IDX_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BYTES);

   // Configuration registers.
   byte_type own_id_ff, peer_one_ff, peer_two_ff;

   // Line collection state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] tlen_ff, tlen_in;
   logic             zero_seen_ff, zero_seen_in;
   byte_type         byte0_ff, byte0_in, byte2_ff, byte2_in, byte4_ff, byte4_in;

   // Mailbox lengths and the bank map of the buffer memory.
   logic [CNT_W-1:0] box1_len_ff, box1_len_in, box2_len_ff, box2_len_in;
   bank_type         line_bank_ff, line_bank_in, box1_bank_ff, box1_bank_in;
   bank_type         box2_bank_ff, box2_bank_in, spare_bank_ff, spare_bank_in;

   // Result sequencer.
   logic             busy_ff, busy_in;
   logic             emit_lamp_ff, emit_lamp_in, emit_level_ff, emit_level_in;
   bank_type         emit_bank_ff, emit_bank_in;
   logic [CNT_W-1:0] emit_idx_ff, emit_idx_in, emit_len_ff, emit_len_in;

   // Output register; the memory read register holds the transmit byte.
   logic     rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic     rsp_lamp_ff, rsp_lamp_in, rsp_last_ff, rsp_last_in;
   byte_type rdata_ff;

   byte_type mem [MEM_DEPTH];

   logic             req_fire, line_end, store_ok, wr_en, out_free, advance, rd_en;
   logic             emit_last, banks_distinct;
   byte_type         rx, b0_eff, b2_eff, b4_eff;
   logic [CNT_W-1:0] tlen_eff;

   assign rx       = req_ch.rx_byte;
   assign req_ch.ready = !busy_ff || (rx != CH_END);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign line_end = req_fire && (rx == CH_END);
   assign store_ok = count_ff < CNT_FULL;
   assign wr_en    = req_fire && store_ok;

   assign b0_eff   = (store_ok && count_ff == CNT_W'(0)) ? rx : byte0_ff;
   assign b2_eff   = (store_ok && count_ff == CNT_W'(2)) ? rx : byte2_ff;
   assign b4_eff   = (store_ok && count_ff == CNT_W'(4)) ? rx : byte4_ff;
   assign tlen_eff = (store_ok && !zero_seen_ff && rx != 8'h00) ?
                     CNT_W'(tlen_ff + 1'b1) : tlen_ff;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign advance   = busy_ff && out_free;
   assign rd_en     = advance && !emit_lamp_ff;
   assign emit_last = CNT_W'(emit_idx_ff + 1'b1) == emit_len_ff;

   assign banks_distinct = line_bank_ff != box1_bank_ff && line_bank_ff != box2_bank_ff
                           && line_bank_ff != spare_bank_ff && box1_bank_ff != box2_bank_ff
                           && box1_bank_ff != spare_bank_ff && box2_bank_ff != spare_bank_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff   <= OWN_ID_RESET;
         peer_one_ff <= PEER_ONE_RESET;
         peer_two_ff <= PEER_TWO_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_OWN_ID:   own_id_ff   <= csr_ch.data;
            REG_PEER_ONE: peer_one_ff <= csr_ch.data;
            REG_PEER_TWO: peer_two_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_in      = count_ff;
      tlen_in       = tlen_ff;
      zero_seen_in  = zero_seen_ff;
      byte0_in      = byte0_ff;
      byte2_in      = byte2_ff;
      byte4_in      = byte4_ff;
      box1_len_in   = box1_len_ff;
      box2_len_in   = box2_len_ff;
      line_bank_in  = line_bank_ff;
      box1_bank_in  = box1_bank_ff;
      box2_bank_in  = box2_bank_ff;
      spare_bank_in = spare_bank_ff;
      busy_in       = busy_ff;
      emit_lamp_in  = emit_lamp_ff;
      emit_level_in = emit_level_ff;
      emit_bank_in  = emit_bank_ff;
      emit_idx_in   = emit_idx_ff;
      emit_len_in   = emit_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_lamp_in   = rsp_lamp_ff;
      rsp_last_in   = rsp_last_ff;

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_lamp_ff;
         rsp_lamp_in  = emit_lamp_ff && emit_level_ff;
         rsp_last_in  = emit_last;
         emit_idx_in  = CNT_W'(emit_idx_ff + 1'b1);
         busy_in      = !emit_last;
      end

      if (wr_en) begin
         count_in     = CNT_W'(count_ff + 1'b1);
         tlen_in      = tlen_eff;
         zero_seen_in = zero_seen_ff || (rx == 8'h00);
         byte0_in     = b0_eff;
         byte2_in     = b2_eff;
         byte4_in     = b4_eff;
      end

      if (line_end) begin
         count_in     = '0;
         tlen_in      = '0;
         zero_seen_in = 1'b0;
         byte0_in     = 8'h00;
         byte2_in     = 8'h00;
         byte4_in     = 8'h00;
         emit_idx_in  = '0;
         emit_lamp_in = 1'b0;
         emit_bank_in = line_bank_ff;
         emit_len_in  = tlen_eff;
         priority if (b0_eff == peer_one_ff && b2_eff == own_id_ff) begin
            box1_len_in  = tlen_eff;
            box1_bank_in = line_bank_ff;
            line_bank_in = box1_bank_ff;
         end else if (b0_eff == peer_two_ff && b2_eff == own_id_ff) begin
            box2_len_in  = tlen_eff;
            box2_bank_in = line_bank_ff;
            line_bank_in = box2_bank_ff;
         end else if (b0_eff != own_id_ff) begin
         end else if (b2_eff == peer_one_ff && b4_eff == CH_POLL_ONE
                      && box1_len_ff != '0) begin
            busy_in      = 1'b1;
            emit_bank_in = box1_bank_ff;
            emit_len_in  = box1_len_ff;
            box1_len_in  = '0;
         end else if (b2_eff == peer_two_ff && b4_eff == CH_POLL_TWO
                      && box2_len_ff != '0) begin
            busy_in      = 1'b1;
            emit_bank_in = box2_bank_ff;
            emit_len_in  = box2_len_ff;
            box2_len_in  = '0;
         end else if (b2_eff == CH_LAMP && (b4_eff == CH_ON || b4_eff == CH_OFF)) begin
            busy_in       = 1'b1;
            emit_lamp_in  = 1'b1;
            emit_level_in = (b4_eff == CH_ON);
            emit_len_in   = CNT_W'(1);
         end else if ((b2_eff == peer_one_ff && b4_eff == CH_POLL_ONE)
                      || (b2_eff == peer_two_ff && b4_eff == CH_POLL_TWO)
                      || ((b2_eff == peer_one_ff || b2_eff == peer_two_ff)
                          && (b4_eff == CH_ON || b4_eff == CH_OFF))) begin
            // The finished line is echoed; new bytes go to the spare bank meanwhile.
            busy_in       = tlen_eff != '0;
            line_bank_in  = spare_bank_ff;
            spare_bank_in = line_bank_ff;
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         tlen_ff       <= '0;
         zero_seen_ff  <= 1'b0;
         byte0_ff      <= 8'h00;
         byte2_ff      <= 8'h00;
         byte4_ff      <= 8'h00;
         box1_len_ff   <= '0;
         box2_len_ff   <= '0;
         line_bank_ff  <= BANK_LINE;
         box1_bank_ff  <= BANK_BOX1;
         box2_bank_ff  <= BANK_BOX2;
         spare_bank_ff <= BANK_SPARE;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         tlen_ff       <= tlen_in;
         zero_seen_ff  <= zero_seen_in;
         byte0_ff      <= byte0_in;
         byte2_ff      <= byte2_in;
         byte4_ff      <= byte4_in;
         box1_len_ff   <= box1_len_in;
         box2_len_ff   <= box2_len_in;
         line_bank_ff  <= line_bank_in;
         box1_bank_ff  <= box1_bank_in;
         box2_bank_ff  <= box2_bank_in;
         spare_bank_ff <= spare_bank_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_lamp_ff  <= emit_lamp_in;
      emit_level_ff <= emit_level_in;
      emit_bank_ff  <= emit_bank_in;
      emit_idx_ff   <= emit_idx_in;
      emit_len_ff   <= emit_len_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_lamp_ff   <= rsp_lamp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{line_bank_ff, count_ff[IDX_W-1:0]}] <= rx;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[{emit_bank_ff, emit_idx_ff[IDX_W-1:0]}];
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_kind = rsp_kind_ff;
   assign rsp_ch.out_byte = rsp_kind_ff ? 8'h00 : rdata_ff;
   assign rsp_ch.lamp_on  = rsp_lamp_ff;
   assign rsp_ch.last     = rsp_last_ff;

   `SMMR_ASSERT_IMP(a_banks_distinct, 1'b1, banks_distinct)
   `SMMR_ASSERT_IMP(a_no_end_while_busy, req_fire && (rx == CH_END), !busy_ff)
   `SMMR_ASSERT_IMP(a_emit_in_range, busy_ff, emit_idx_ff < emit_len_ff)
   `SMMR_ASSERT_IMP(a_lamp_result_form, rsp_valid_ff && rsp_kind_ff, rsp_last_ff)
   `SMMR_ASSERT_NEXT(a_line_restarts, line_end, count_ff == '0)

endmodule

/* tb/serial_message_mailbox_router_core_tb.sv */
// Self-checking testbench for serial_message_mailbox_router_core.
// It predicts each response from its own model of the line, mailbox and lamp logic.
// It depends on smmr_pkg and the channel interfaces in smmr_if.sv.
`timescale 1ns / 1ps

module serial_message_mailbox_router_core_tb;
   import smmr_pkg::*;

   localparam int LINE_BYTES     = 15;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = LINE_BYTES + 4;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_type;

   typedef struct packed {
      logic     kind;
      byte_type data;
      logic     lamp;
      logic     last;
   } router_result_type;

   logic clock;
   logic reset;

   smmr_req_if req_bus ();
   smmr_rsp_if rsp_bus ();
   smmr_csr_if csr_bus ();

   serial_message_mailbox_router_core #(.LINE_BYTES(LINE_BYTES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Predictor state.
   byte_type cfg_own;
   byte_type cfg_peer_one;
   byte_type cfg_peer_two;
   byte_type line_img [LINE_BYTES];
   int       line_fill;
   byte_type mailbox [2][LINE_BYTES];
   int       mailbox_len [2];
   logic     lamp_state;

   router_result_type pending_results [$];

   int             fail_count    = 0;
   int             bytes_sent    = 0;
   int             results_seen  = 0;
   int             reg_writes    = 0;
   int             setting_count = 0;
   int             burst_left    = 0;
   int             gap_max       = 0;
   ready_mode_type rsp_mode      = READY_ALWAYS;
   logic [7:0]     stall_mask    = 8'b1011_0110;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int text_length(input byte_type src [LINE_BYTES]);
      int n;
      n = 0;
      while (n < LINE_BYTES && src[n] != 8'h00) n++;
      return n;
   endfunction

   task automatic emit_text(input byte_type src [LINE_BYTES], input int count);
      router_result_type r;
      for (int k = 0; k < count; k++) begin
         r.kind = 1'b0;
         r.data = src[k];
         r.lamp = 1'b0;
         r.last = (k + 1 == count);
         pending_results.push_back(r);
      end
   endtask

   task automatic emit_lamp(input logic level);
      router_result_type r;
      lamp_state = level;
      r.kind = 1'b1;
      r.data = 8'h00;
      r.lamp = level;
      r.last = 1'b1;
      pending_results.push_back(r);
   endtask

   task automatic store_mailbox(input int slot);
      int n;
      n = text_length(line_img);
      for (int k = 0; k < LINE_BYTES; k++)
         mailbox[slot][k] = (k < n) ? line_img[k] : 8'h00;
      mailbox_len[slot] = n;
   endtask

   task automatic poll_mailbox(input int slot);
      if (mailbox_len[slot] == 0) begin
         emit_text(line_img, text_length(line_img));
      end else begin
         emit_text(mailbox[slot], mailbox_len[slot]);
         for (int k = 0; k < LINE_BYTES; k++) mailbox[slot][k] = 8'h00;
         mailbox_len[slot] = 0;
      end
   endtask

   task automatic decode_line();
      byte_type a;
      byte_type b;
      byte_type c;
      a = line_img[0];
      b = line_img[2];
      c = line_img[4];
      if (a == cfg_peer_one && b == cfg_own) begin
         store_mailbox(0);
      end else if (a == cfg_peer_two && b == cfg_own) begin
         store_mailbox(1);
      end else if (a == cfg_own) begin
         if (b == cfg_peer_one && c == CH_POLL_ONE) begin
            poll_mailbox(0);
         end else if (b == cfg_peer_two && c == CH_POLL_TWO) begin
            poll_mailbox(1);
         end else if (b == CH_LAMP && c == CH_ON) begin
            emit_lamp(1'b1);
         end else if (b == CH_LAMP && c == CH_OFF) begin
            emit_lamp(1'b0);
         end else if ((b == cfg_peer_one || b == cfg_peer_two)
                      && (c == CH_ON || c == CH_OFF)) begin
            emit_text(line_img, text_length(line_img));
         end
      end
   endtask

   task automatic predict_rx(input byte_type value);
      if (line_fill < LINE_BYTES) begin
         line_img[line_fill] = value;
         line_fill++;
      end
      if (value == CH_END) begin
         decode_line();
         for (int k = 0; k < LINE_BYTES; k++) line_img[k] = 8'h00;
         line_fill = 0;
      end
   endtask

   task automatic reset_predictor();
      cfg_own      = OWN_ID_RESET;
      cfg_peer_one = PEER_ONE_RESET;
      cfg_peer_two = PEER_TWO_RESET;
      for (int k = 0; k < LINE_BYTES; k++) begin
         line_img[k]   = 8'h00;
         mailbox[0][k] = 8'h00;
         mailbox[1][k] = 8'h00;
      end
      line_fill      = 0;
      mailbox_len[0] = 0;
      mailbox_len[1] = 0;
      lamp_state     = 1'b0;
   endtask

   // Response checker.
   always @(posedge clock) begin
      router_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected response transfer: kind %0d byte %02h lamp %0d last %0d",
                   rsp_bus.out_kind, rsp_bus.out_byte, rsp_bus.lamp_on, rsp_bus.last);
            fail_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_bus.out_kind !== exp_r.kind) begin
               $error("out_kind mismatch: expected %0d, actual %0d",
                      exp_r.kind, rsp_bus.out_kind);
               fail_count++;
            end
            if (rsp_bus.out_byte !== exp_r.data) begin
               $error("out_byte mismatch: expected %02h, actual %02h",
                      exp_r.data, rsp_bus.out_byte);
               fail_count++;
            end
            if (rsp_bus.lamp_on !== exp_r.lamp) begin
               $error("lamp_on mismatch: expected %0d, actual %0d",
                      exp_r.lamp, rsp_bus.lamp_on);
               fail_count++;
            end
            if (rsp_bus.last !== exp_r.last) begin
               $error("last mismatch: expected %0d, actual %0d", exp_r.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // Response backpressure.
   always @(negedge clock) begin
      case (rsp_mode)
         READY_ALWAYS: begin
            rsp_bus.ready = 1'b1;
         end
         READY_RANDOM: begin
            rsp_bus.ready = ($urandom_range(0, 9) < 7);
         end
         default: begin
            rsp_bus.ready = stall_mask[0];
            stall_mask    = {stall_mask[0], stall_mask[7:1]};
         end
      endcase
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog expired after %0d cycles without a transfer.", WATCHDOG_LIMIT);
      $display("** serial_message_mailbox_router_core: FAILED **");
      $finish;
   end

   task automatic send_byte(input byte_type value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid   = 1'b1;
      req_bus.rx_byte = value;
      do @(posedge clock); while (!req_bus.ready);
      predict_rx(value);
      bytes_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_line(input byte_type bytes [$]);
      foreach (bytes[k]) send_byte(bytes[k]);
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      burst_left    = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input byte_type value);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         REG_OWN_ID:   cfg_own      = value;
         REG_PEER_ONE: cfg_peer_one = value;
         REG_PEER_TWO: cfg_peer_two = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_ids(input byte_type own, input byte_type peer_one,
                          input byte_type peer_two);
      wait_idle();
      write_reg(REG_OWN_ID, own);
      write_reg(REG_PEER_ONE, peer_one);
      write_reg(REG_PEER_TWO, peer_two);
      setting_count++;
   endtask

   function automatic byte_type text_byte();
      byte_type b;
      do b = byte_type'($urandom_range(1, 255)); while (b == CH_END);
      return b;
   endfunction

   task automatic build_line(output byte_type line_q [$]);
      int       kind;
      int       extra;
      byte_type peer;
      kind = $urandom_range(0, 99);
      peer = $urandom_range(0, 1) ? cfg_peer_two : cfg_peer_one;
      if (kind < 14) begin
         line_q = '{cfg_peer_one, text_byte(), cfg_own};
         extra  = $urandom_range(0, 10);
      end else if (kind < 28) begin
         line_q = '{cfg_peer_two, text_byte(), cfg_own};
         extra  = $urandom_range(0, 10);
      end else if (kind < 42) begin
         line_q = '{cfg_own, text_byte(), cfg_peer_one, text_byte(), CH_POLL_ONE};
         extra  = $urandom_range(0, 2);
      end else if (kind < 56) begin
         line_q = '{cfg_own, text_byte(), cfg_peer_two, text_byte(), CH_POLL_TWO};
         extra  = $urandom_range(0, 2);
      end else if (kind < 66) begin
         line_q = '{cfg_own, text_byte(), CH_LAMP, text_byte(),
                    $urandom_range(0, 1) ? CH_ON : CH_OFF};
         extra  = $urandom_range(0, 2);
      end else if (kind < 78) begin
         line_q = '{cfg_own, text_byte(), peer, text_byte(),
                    $urandom_range(0, 1) ? CH_ON : CH_OFF};
         extra  = $urandom_range(0, 8);
      end else if (kind < 88) begin
         // Lines at or past the store size, so trailing bytes may get dropped.
         if ($urandom_range(0, 1))
            line_q = '{cfg_peer_one, text_byte(), cfg_own};
         else
            line_q = '{cfg_own, text_byte(), peer, text_byte(), CH_ON};
         extra = $urandom_range(LINE_BYTES - line_q.size() - 1, 20 - line_q.size());
      end else begin
         line_q.delete();
         extra = 0;
         repeat ($urandom_range(1, 18)) line_q.push_back(byte_type'($urandom_range(0, 255)));
      end
      repeat (extra) line_q.push_back(text_byte());
      if (line_q.size() > 1 && $urandom_range(0, 7) == 0)
         line_q[$urandom_range(1, line_q.size() - 1)] = 8'h00;
      line_q.push_back(CH_END);
   endtask

   task automatic run_random_lines(input int budget);
      int       start;
      byte_type line_q [$];
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         if ($urandom_range(0, 5) == 0) begin
            rsp_mode   = ready_mode_type'($urandom_range(0, 2));
            gap_max    = $urandom_range(0, 2) * 4;
            stall_mask = byte_type'($urandom_range(0, 255)) | 8'h01;
         end
         build_line(line_q);
         send_line(line_q);
      end
   endtask

   task automatic test_mailboxes();
      byte_type line_q [$];
      gap_max  = 0;
      rsp_mode = READY_ALWAYS;
      line_q = '{PEER_ONE_RESET, 8'hFF, OWN_ID_RESET, CH_END};
      send_line(line_q);
      // A zero byte cuts the stored message short.
      line_q = '{PEER_TWO_RESET, 8'h00, OWN_ID_RESET, CH_END};
      send_line(line_q);
      line_q = '{OWN_ID_RESET, 8'h2E, PEER_ONE_RESET, 8'h2E, CH_POLL_ONE, CH_END};
      send_line(line_q);
      line_q = '{OWN_ID_RESET, 8'h2E, PEER_TWO_RESET, 8'h2E, CH_POLL_TWO, CH_END};
      send_line(line_q);
      // The mailbox is empty now, so the poll line comes back.
      send_line(line_q);
   endtask

   task automatic test_lamp_and_echo();
      byte_type line_q [$];
      rsp_mode = READY_PATTERN;
      line_q = '{OWN_ID_RESET, 8'h01, CH_LAMP, 8'hFE, CH_ON, CH_END};
      send_line(line_q);
      line_q = '{OWN_ID_RESET, 8'h80, CH_LAMP, 8'h7F, CH_OFF, CH_END};
      send_line(line_q);
      line_q = '{OWN_ID_RESET, 8'hFF, PEER_TWO_RESET, 8'h55, CH_OFF, CH_END};
      send_line(line_q);
   endtask

   task automatic test_extreme_ids();
      set_ids(8'hFF, 8'h00, 8'h7F);
      gap_max  = 3;
      rsp_mode = READY_PATTERN;
      run_random_lines(60);
      set_ids(8'h00, 8'hFF, 8'h01);
      run_random_lines(50);
   endtask

   task automatic test_random_ids();
      set_ids(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)),
              byte_type'($urandom_range(0, 255)));
      gap_max  = 8;
      rsp_mode = READY_RANDOM;
      run_random_lines(150);
   endtask

   task automatic test_default_ids();
      set_ids(OWN_ID_RESET, PEER_ONE_RESET, PEER_TWO_RESET);
      run_random_lines(100);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_OWN_ID;
      csr_bus.data    = 8'h00;
      reset_predictor();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_mailboxes();
      test_lamp_and_echo();
      test_extreme_ids();
      test_random_ids();
      test_default_ids();
      wait_idle();

      $display("Sent %0d bytes and checked %0d responses.", bytes_sent, results_seen);
      $display("Made %0d register writes over %0d id settings.", reg_writes, setting_count);
      if (fail_count == 0)
         $display("** serial_message_mailbox_router_core: PASSED **");
      else
         $display("** serial_message_mailbox_router_core: FAILED **");
      $finish;
   end

endmodule
